### design/mts_pkg.sv
// Shared types, byte codes and helpers for the markup tag stripper.
`timescale 1ns / 1ps

package mts_pkg;

    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_TAG     = 3'd1,
        MODE_PI      = 3'd2,
        MODE_DECL    = 3'd3,
        MODE_COMMENT = 3'd4
    } mode_t;

    localparam int HIST_LEN = 6;
    localparam logic [2:0] SEEN_MAX = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_M   = 8'h6D;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_P   = 8'h70;
    localparam logic [7:0] CH_LO_Y   = 8'h79;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_O   = 8'h6F;
    localparam logic [7:0] CH_LO_D   = 8'h64;

    // Mode, quote marker, byte history (entry 0 newest) and judged-byte count.
    typedef struct packed {
        mode_t                        mode;
        logic [7:0]                   quote;
        logic [HIST_LEN-1:0][7:0]     hist;
        logic [2:0]                   seen;
    } mts_ctx_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

endpackage

### design/mts_judge.sv
// Combinational judgment of one byte: keep decision and next tracking state.
`timescale 1ns / 1ps

module mts_judge #(
    parameter int COUNTER_BITS = 8
) (
    input  logic [7:0]              c,
    input  logic [7:0]              next_c,
    input  mts_pkg::mts_ctx_t       ctx_in,
    input  logic [COUNTER_BITS-1:0] depth_in,
    input  logic [COUNTER_BITS-1:0] paren_in,
    output mts_pkg::mts_ctx_t       ctx_out,
    output logic [COUNTER_BITS-1:0] depth_out,
    output logic [COUNTER_BITS-1:0] paren_out,
    output logic                    keep
);
    import mts_pkg::*;

    localparam logic [COUNTER_BITS-1:0] DEPTH_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] PAREN_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic [COUNTER_BITS-1:0] PAREN_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    logic [7:0] h0;
    logic [7:0] h1;
    logic       doctype;
    logic       is_text;

    assign h0      = ctx_in.hist[0];
    assign h1      = ctx_in.hist[1];
    assign is_text = (ctx_in.mode == MODE_TEXT);
    assign doctype = (ctx_in.seen == SEEN_MAX)
                   && (fold(ctx_in.hist[0]) == CH_LO_P) && (fold(ctx_in.hist[1]) == CH_LO_Y)
                   && (fold(ctx_in.hist[2]) == CH_LO_T) && (fold(ctx_in.hist[3]) == CH_LO_C)
                   && (fold(ctx_in.hist[4]) == CH_LO_O) && (fold(ctx_in.hist[5]) == CH_LO_D);

    always_comb begin
        mode_t      mode_n;
        logic [7:0] quote_n;
        mode_n    = ctx_in.mode;
        quote_n   = ctx_in.quote;
        depth_out = depth_in;
        paren_out = paren_in;
        keep      = 1'b0;
        case (c)
            CH_LT: begin
                if (is_space(next_c)) begin
                    keep = is_text;
                end else if (is_text) begin
                    quote_n = CH_LT;
                    mode_n  = MODE_TAG;
                end else if (ctx_in.mode == MODE_TAG) begin
                    if (depth_in != DEPTH_MAX) depth_out = depth_in + 1'b1;
                end
            end
            CH_LPAREN, CH_RPAREN: begin
                if (ctx_in.mode == MODE_PI) begin
                    if (ctx_in.quote != CH_DQUOTE && ctx_in.quote != CH_SQUOTE) begin
                        quote_n = c;
                        if (c == CH_LPAREN) begin
                            if (paren_in != PAREN_MAX) paren_out = paren_in + 1'b1;
                        end else begin
                            if (paren_in != PAREN_MIN) paren_out = paren_in - 1'b1;
                        end
                    end
                end else if (is_text) begin
                    keep = 1'b1;
                end
            end
            CH_GT: begin
                if (depth_in != '0) begin
                    depth_out = depth_in - 1'b1;
                end else begin
                    case (ctx_in.mode)
                        MODE_TAG: begin
                            quote_n = CH_GT;
                            mode_n  = MODE_TEXT;
                        end
                        MODE_PI: begin
                            if (paren_in == '0 && ctx_in.quote != CH_DQUOTE && h0 == CH_QMARK)
                                mode_n = MODE_TEXT;
                        end
                        MODE_DECL: begin
                            mode_n = MODE_TEXT;
                        end
                        MODE_COMMENT: begin
                            if (ctx_in.seen >= 3'd2 && h0 == CH_DASH && h1 == CH_DASH)
                                mode_n = MODE_TEXT;
                        end
                        default: begin
                            keep = 1'b1;
                        end
                    endcase
                end
            end
            CH_DQUOTE, CH_SQUOTE: begin
                if (ctx_in.mode == MODE_PI && h0 != CH_BSLASH) begin
                    if (ctx_in.quote == c) quote_n = CH_NUL;
                    else if (ctx_in.quote != CH_BSLASH) quote_n = c;
                end else if (is_text) begin
                    keep = 1'b1;
                end
            end
            CH_BANG: begin
                if (ctx_in.mode == MODE_TAG && h0 == CH_LT) begin
                    mode_n  = MODE_DECL;
                    quote_n = CH_BANG;
                end else begin
                    keep = is_text;
                end
            end
            CH_DASH: begin
                if (ctx_in.mode == MODE_DECL && ctx_in.seen >= 3'd2
                        && h0 == CH_DASH && h1 == CH_BANG) begin
                    mode_n = MODE_COMMENT;
                end else begin
                    keep = is_text;
                end
            end
            CH_QMARK, CH_UP_E, CH_LO_E, CH_LO_L: begin
                if (c == CH_QMARK && ctx_in.mode == MODE_TAG && h0 == CH_LT) begin
                    paren_out = '0;
                    mode_n    = MODE_PI;
                end else if (c != CH_LO_L && ctx_in.mode == MODE_DECL && doctype) begin
                    mode_n = MODE_TAG;
                end else if (ctx_in.mode == MODE_PI && ctx_in.seen >= 3'd3
                        && h0 == CH_LO_M && h1 == CH_LO_X) begin
                    mode_n = MODE_TAG;
                end else begin
                    keep = is_text;
                end
            end
            default: begin
                keep = is_text;
            end
        endcase
        ctx_out.mode  = mode_n;
        ctx_out.quote = quote_n;
        ctx_out.hist  = {ctx_in.hist[HIST_LEN-2:0], c};
        ctx_out.seen  = (ctx_in.seen != SEEN_MAX) ? ctx_in.seen + 3'd1 : ctx_in.seen;
    end

endmodule

### design/markup_tag_stripper.sv
// Top level of the markup tag stripper: byte hold-back, state and result buffer.
//
//   channel | ports                                   | direction
//   input   | s_valid s_ready s_char_in s_last_byte   | bytes in
//   result  | m_valid m_ready m_kept_char m_is_end    | kept bytes / end marker out
//           | m_run_last                              |
//
// Each byte is judged when its successor arrives, so a transaction yields zero
// to three results, drained one per cycle as m_ready allows from a three-entry
// result buffer. One byte is taken per cycle while it is empty or its final
// entry leaves. Reset clears the mode state, the held byte and the buffer.
`timescale 1ns / 1ps

module markup_tag_stripper #(
    parameter int COUNTER_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_kept_char,
    output logic       m_is_end,
    output logic       m_run_last
);
    import mts_pkg::*;

    mts_ctx_t                ctx_reg, ctx_next;
    logic [COUNTER_BITS-1:0] depth_reg, depth_next;
    logic [COUNTER_BITS-1:0] paren_reg, paren_next;
    logic [7:0]              held_char_reg, held_char_next;
    logic                    held_valid_reg, held_valid_next;

    logic [2:0][7:0]         buf_char_reg, buf_char_next;
    logic [2:0]              buf_end_reg, buf_end_next;
    logic [1:0]              count_reg, count_next;

    mts_ctx_t                a_ctx, b_ctx, m_ctx;
    logic [COUNTER_BITS-1:0] a_depth, b_depth, m_depth;
    logic [COUNTER_BITS-1:0] a_paren, b_paren, m_paren;
    logic                    a_keep, b_keep;
    logic                    accept;

    mts_judge #(.COUNTER_BITS(COUNTER_BITS)) u_judge_held (
        .c         (held_char_reg),
        .next_c    (s_char_in),
        .ctx_in    (ctx_reg),
        .depth_in  (depth_reg),
        .paren_in  (paren_reg),
        .ctx_out   (a_ctx),
        .depth_out (a_depth),
        .paren_out (a_paren),
        .keep      (a_keep)
    );

    // state after the held byte, if any
    assign m_ctx   = held_valid_reg ? a_ctx   : ctx_reg;
    assign m_depth = held_valid_reg ? a_depth : depth_reg;
    assign m_paren = held_valid_reg ? a_paren : paren_reg;

    mts_judge #(.COUNTER_BITS(COUNTER_BITS)) u_judge_last (
        .c         (s_char_in),
        .next_c    (CH_NUL),
        .ctx_in    (m_ctx),
        .depth_in  (m_depth),
        .paren_in  (m_paren),
        .ctx_out   (b_ctx),
        .depth_out (b_depth),
        .paren_out (b_paren),
        .keep      (b_keep)
    );

    assign s_ready     = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign accept      = s_valid && s_ready;
    assign m_valid     = (count_reg != 2'd0);
    assign m_kept_char = buf_char_reg[0];
    assign m_is_end    = buf_end_reg[0];
    assign m_run_last  = (count_reg == 2'd1);

    always_comb begin
        logic [1:0] n;
        n               = 2'd0;
        ctx_next        = ctx_reg;
        depth_next      = depth_reg;
        paren_next      = paren_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        buf_char_next   = buf_char_reg;
        buf_end_next    = buf_end_reg;
        count_next      = count_reg;
        // drain
        if (m_valid && m_ready) begin
            buf_char_next = {CH_NUL, buf_char_reg[2:1]};
            buf_end_next  = {1'b0, buf_end_reg[2:1]};
            count_next    = count_reg - 2'd1;
        end
        if (accept) begin
            if (held_valid_reg && a_keep) begin
                buf_char_next[n] = held_char_reg;
                buf_end_next[n]  = 1'b0;
                n                = n + 2'd1;
            end
            if (s_last_byte) begin
                if (b_keep) begin
                    buf_char_next[n] = s_char_in;
                    buf_end_next[n]  = 1'b0;
                    n                = n + 2'd1;
                end
                buf_char_next[n] = CH_NUL;
                buf_end_next[n]  = 1'b1;
                n                = n + 2'd1;
                ctx_next         = '0;
                depth_next       = '0;
                paren_next       = '0;
                held_char_next   = CH_NUL;
                held_valid_next  = 1'b0;
            end else begin
                ctx_next        = m_ctx;
                depth_next      = m_depth;
                paren_next      = m_paren;
                held_char_next  = s_char_in;
                held_valid_next = 1'b1;
            end
            count_next = n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg        <= '0;
            depth_reg      <= '0;
            paren_reg      <= '0;
            held_char_reg  <= CH_NUL;
            held_valid_reg <= 1'b0;
            count_reg      <= 2'd0;
        end else begin
            ctx_reg        <= ctx_next;
            depth_reg      <= depth_next;
            paren_reg      <= paren_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_char_reg <= buf_char_next;
        buf_end_reg  <= buf_end_next;
    end

endmodule

### sim/markup_tag_stripper_tb.sv
// Testbench for markup_tag_stripper: directed table and random messages checked by a predictor.
`timescale 1ns / 1ps

module markup_tag_stripper_tb;
    import mts_pkg::*;

    localparam int CNT_BITS     = 4;
    localparam int RAND_ITEMS   = 275;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [CNT_BITS-1:0] DEPTH_TOP = '1;
    localparam logic signed [CNT_BITS-1:0] BAL_TOP = {1'b0, {(CNT_BITS-1){1'b1}}};
    localparam logic signed [CNT_BITS-1:0] BAL_BOT = {1'b1, {(CNT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [7:0] kept;
        logic       is_end;
        logic       run_last;
    } strip_out_t;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        int         n_typed;
        logic [7:0] k0;
        logic [7:0] k1;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_kept_char;
    logic       m_is_end;
    logic       m_run_last;

    markup_tag_stripper #(
        .COUNTER_BITS(CNT_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .s_last_byte(s_last_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kept_char(m_kept_char),
        .m_is_end   (m_is_end),
        .m_run_last (m_run_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state
    mode_t                       st_mode;
    logic [7:0]                  st_quote;
    logic [CNT_BITS-1:0]         st_depth;
    logic signed [CNT_BITS-1:0]  st_bal;
    logic [7:0]                  st_hist [HIST_LEN];
    logic [2:0]                  st_seen;
    logic [7:0]                  held_byte;
    logic                        held_ok;

    strip_out_t  kept_q [$];
    logic [7:0]  msg_q [$];
    bit          calm = 1'b0;
    int          error_cnt = 0;
    int          bytes_sent = 0;
    int          msgs_sent = 0;
    int          results_seen = 0;
    int          cycle_cnt = 0;
    int          depth_peak = 0;
    int          bal_hi = 0;
    int          bal_lo = 0;

    string tag_names [4] = '{"p", "div", "b", "em"};
    string xml_tails [4] = '{"l version='1.0'?>", "e?>", "E x?>", "?>"};
    string pi_bits  = "()'\"\\a ?>x";
    string odd_bits = "<>!-?()'\"\\eElmx ";

    stim_row_t dir_rows [25] = '{
        '{8'hFF,     1'b1,  1, 8'hFF,  8'h00},
        '{CH_LT,     1'b0,  0, 8'h00,  8'h00},
        '{8'h09,     1'b0,  1, CH_LT,  8'h00},
        '{CH_NUL,    1'b1,  2, 8'h09,  CH_NUL},
        '{CH_LT,     1'b0, -1, 8'h00,  8'h00},
        '{CH_BANG,   1'b0, -1, 8'h00,  8'h00},
        '{"D",       1'b0, -1, 8'h00,  8'h00},
        '{"O",       1'b0, -1, 8'h00,  8'h00},
        '{"C",       1'b0, -1, 8'h00,  8'h00},
        '{"T",       1'b0, -1, 8'h00,  8'h00},
        '{"Y",       1'b0, -1, 8'h00,  8'h00},
        '{"P",       1'b0, -1, 8'h00,  8'h00},
        '{CH_UP_E,   1'b0, -1, 8'h00,  8'h00},
        '{CH_GT,     1'b0, -1, 8'h00,  8'h00},
        '{"z",       1'b1, -1, 8'h00,  8'h00},
        '{CH_LT,     1'b0, -1, 8'h00,  8'h00},
        '{CH_BANG,   1'b0, -1, 8'h00,  8'h00},
        '{CH_DASH,   1'b0, -1, 8'h00,  8'h00},
        '{CH_DASH,   1'b0, -1, 8'h00,  8'h00},
        '{CH_GT,     1'b0, -1, 8'h00,  8'h00},
        '{"k",       1'b1, -1, 8'h00,  8'h00},
        '{CH_LT,     1'b0, -1, 8'h00,  8'h00},
        '{CH_QMARK,  1'b0, -1, 8'h00,  8'h00},
        '{CH_GT,     1'b0, -1, 8'h00,  8'h00},
        '{CH_RPAREN, 1'b1, -1, 8'h00,  8'h00}
    };

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit doctype_seen();
        return st_seen == SEEN_MAX && lower_ascii(st_hist[0]) == CH_LO_P &&
               lower_ascii(st_hist[1]) == CH_LO_Y && lower_ascii(st_hist[2]) == CH_LO_T &&
               lower_ascii(st_hist[3]) == CH_LO_C && lower_ascii(st_hist[4]) == CH_LO_O &&
               lower_ascii(st_hist[5]) == CH_LO_D;
    endfunction

    function automatic void strip_clear();
        st_mode   = MODE_TEXT;
        st_quote  = CH_NUL;
        st_depth  = '0;
        st_bal    = '0;
        st_seen   = '0;
        held_byte = CH_NUL;
        held_ok   = 1'b0;
        foreach (st_hist[i]) st_hist[i] = CH_NUL;
    endfunction

    // Decide one byte given its successor; true when the byte lies outside markup.
    function automatic bit judge_byte(input logic [7:0] c, input logic [7:0] nxt);
        bit         keep;
        logic [7:0] h0;
        logic [7:0] h1;
        int         i;
        keep = 1'b0;
        h0 = st_hist[0];
        h1 = st_hist[1];
        case (c)
            CH_LT: begin
                if (is_blank(nxt)) begin
                    keep = (st_mode == MODE_TEXT);
                end else if (st_mode == MODE_TEXT) begin
                    st_quote = CH_LT;
                    st_mode  = MODE_TAG;
                end else if (st_mode == MODE_TAG) begin
                    if (st_depth != DEPTH_TOP) st_depth++;
                end
            end
            CH_LPAREN, CH_RPAREN: begin
                if (st_mode == MODE_PI) begin
                    if (st_quote != CH_DQUOTE && st_quote != CH_SQUOTE) begin
                        st_quote = c;
                        if (c == CH_LPAREN) begin
                            if (st_bal != BAL_TOP) st_bal++;
                        end else if (st_bal != BAL_BOT) begin
                            st_bal--;
                        end
                    end
                end else begin
                    keep = (st_mode == MODE_TEXT);
                end
            end
            CH_GT: begin
                if (st_depth != 0) begin
                    st_depth--;
                end else begin
                    case (st_mode)
                        MODE_TAG: begin
                            st_quote = CH_GT;
                            st_mode  = MODE_TEXT;
                        end
                        MODE_PI: begin
                            if (st_bal == 0 && st_quote != CH_DQUOTE && h0 == CH_QMARK)
                                st_mode = MODE_TEXT;
                        end
                        MODE_DECL: st_mode = MODE_TEXT;
                        MODE_COMMENT: begin
                            if (st_seen >= 2 && h0 == CH_DASH && h1 == CH_DASH)
                                st_mode = MODE_TEXT;
                        end
                        default: keep = 1'b1;
                    endcase
                end
            end
            CH_DQUOTE, CH_SQUOTE: begin
                if (st_mode == MODE_PI && h0 != CH_BSLASH) begin
                    if (st_quote == c) st_quote = CH_NUL;
                    else if (st_quote != CH_BSLASH) st_quote = c;
                end else begin
                    keep = (st_mode == MODE_TEXT);
                end
            end
            CH_BANG: begin
                if (st_mode == MODE_TAG && h0 == CH_LT) begin
                    st_mode  = MODE_DECL;
                    st_quote = CH_BANG;
                end else begin
                    keep = (st_mode == MODE_TEXT);
                end
            end
            CH_DASH: begin
                if (st_mode == MODE_DECL && st_seen >= 2 && h0 == CH_DASH && h1 == CH_BANG)
                    st_mode = MODE_COMMENT;
                else
                    keep = (st_mode == MODE_TEXT);
            end
            CH_QMARK, CH_UP_E, CH_LO_E, CH_LO_L: begin
                if (c == CH_QMARK && st_mode == MODE_TAG && h0 == CH_LT) begin
                    st_bal  = '0;
                    st_mode = MODE_PI;
                end else if (c != CH_LO_L && st_mode == MODE_DECL && doctype_seen()) begin
                    st_mode = MODE_TAG;
                end else if (st_mode == MODE_PI && st_seen >= 3 && h0 == CH_LO_M &&
                             h1 == CH_LO_X) begin
                    st_mode = MODE_TAG;
                end else begin
                    keep = (st_mode == MODE_TEXT);
                end
            end
            default: keep = (st_mode == MODE_TEXT);
        endcase
        for (i = HIST_LEN - 1; i > 0; i--) st_hist[i] = st_hist[i-1];
        st_hist[0] = c;
        if (st_seen != SEEN_MAX) st_seen++;
        if (int'(st_depth) > depth_peak) depth_peak = int'(st_depth);
        if (int'(st_bal) > bal_hi) bal_hi = int'(st_bal);
        if (int'(st_bal) < bal_lo) bal_lo = int'(st_bal);
        return keep;
    endfunction

    // Results caused by one accepted byte.
    function automatic int strip_step(input logic [7:0] c, input logic lst,
                                      output strip_out_t res [3]);
        int n;
        n = 0;
        foreach (res[i]) res[i] = '0;
        if (held_ok && judge_byte(held_byte, c)) begin
            res[n] = {held_byte, 2'b00};
            n++;
        end
        if (lst) begin
            if (judge_byte(c, CH_NUL)) begin
                res[n] = {c, 2'b00};
                n++;
            end
            res[n] = {CH_NUL, 2'b10};
            n++;
            strip_clear();
        end else begin
            held_byte = c;
            held_ok   = 1'b1;
        end
        if (n > 0) res[n-1].run_last = 1'b1;
        return n;
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endfunction

    function automatic void add_cased(input string s);
        logic [7:0] b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(1))
                b = b ^ 8'h20;
            msg_q.push_back(b);
        end
    endfunction

    function automatic void add_text(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) msg_q.push_back(8'($urandom_range(32, 126)));
    endfunction

    function automatic void add_picks(input string s, input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) msg_q.push_back(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    // Mostly well-formed markup with random content, plus noise and broken pieces.
    function automatic void make_message();
        int base;
        msg_q.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 11))
                0: add_text(1, 6);
                1: repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom));
                2: begin
                    add_str("<");
                    add_cased(tag_names[$urandom_range(0, 3)]);
                    if ($urandom_range(1)) add_str(" id='x>y'");
                    add_str(">");
                end
                3: begin
                    add_str("</");
                    add_cased(tag_names[$urandom_range(0, 3)]);
                    add_str(">");
                end
                4: begin
                    add_str("<!--");
                    add_text(0, 4);
                    add_str($urandom_range(3) == 0 ? "->" : "-->");
                end
                5: begin
                    base = msg_q.size();
                    add_cased("<!DOCTYPE html>");
                    if ($urandom_range(5) == 0)
                        msg_q[base + 2 + $urandom_range(0, 6)] ^= 8'h80;
                end
                6: begin
                    add_str("<?xm");
                    add_str(xml_tails[$urandom_range(0, 3)]);
                end
                7: begin
                    add_str("<?");
                    add_picks(pi_bits, 1, 10);
                    add_str("?>");
                end
                8: begin
                    add_str("<a<b");
                    repeat ($urandom_range(0, 2)) add_str("<c");
                    add_str(">x>y>");
                end
                9: begin
                    add_str("<");
                    msg_q.push_back($urandom_range(5) == 5 ? CH_SPACE : 8'($urandom_range(9, 13)));
                    add_text(1, 2);
                end
                10: add_picks(odd_bits, 1, 8);
                default: begin
                    repeat ($urandom_range(1, 3))
                        msg_q.push_back($urandom_range(5) == 5 ? CH_SPACE :
                                        8'($urandom_range(9, 13)));
                end
            endcase
        end
    endfunction

    task automatic note_error(input string msg);
        error_cnt++;
        if (error_cnt <= 10) $display("%s", msg);
    endtask

    // Starts and ends at a falling edge; predicts when the transaction completes.
    task automatic send_item(input logic [7:0] ch, input logic lst, input int n_typed,
                             input logic [7:0] k0, input logic [7:0] k1);
        strip_out_t res [3];
        int         n;
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_in   <= ch;
        s_last_byte <= lst;
        do @(posedge aclk); while (!s_ready);
        n = strip_step(ch, lst, res);
        if (n_typed >= 0) begin
            n = 0;
            if (n_typed > 0) res[n++] = {k0, 2'b00};
            if (n_typed > 1) res[n++] = {k1, 2'b00};
            if (lst) res[n++] = {CH_NUL, 2'b10};
            if (n > 0) res[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) kept_q.push_back(res[i]);
        bytes_sent++;
        if (lst) msgs_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_item(msg_q[i], i == msg_q.size() - 1, -1, 8'h00, 8'h00);
    endtask

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        strip_out_t got;
        strip_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kept_char, m_is_end, m_run_last};
            results_seen++;
            if (kept_q.size() == 0) begin
                note_error($sformatf("unexpected result: char %02h end %0b last %0b",
                                     got.kept, got.is_end, got.run_last));
            end else begin
                want = kept_q.pop_front();
                if (got !== want)
                    note_error($sformatf(
                        "result %0d: expected char %02h end %0b last %0b, got %02h %0b %0b",
                        results_seen, want.kept, want.is_end, want.run_last,
                        got.kept, got.is_end, got.run_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("markup_tag_stripper_tb: errors");
            $finish;
        end
    end

    initial begin
        int rand_start;
        strip_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].ch, dir_rows[r].lst, dir_rows[r].n_typed,
                      dir_rows[r].k0, dir_rows[r].k1);

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_ITEMS) begin
            calm = (bytes_sent - rand_start >= 120) && (bytes_sent - rand_start < 200);
            make_message();
            send_message();
        end
        calm = 1'b0;

        // Drive the nesting depth and the paren balance into both limits.
        msg_q.delete();
        add_str("<a");
        repeat (18) msg_q.push_back(CH_LT);
        add_str("b>z");
        send_message();
        msg_q.delete();
        add_str("<?");
        repeat (10) msg_q.push_back(CH_LPAREN);
        add_str(")q");
        send_message();
        msg_q.delete();
        add_str("<?");
        repeat (10) msg_q.push_back(CH_RPAREN);
        add_str("(q");
        send_message();

        s_valid <= 1'b0;
        while (kept_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d bytes in %0d messages, %0d results checked, %0d errors",
                 bytes_sent, msgs_sent, results_seen, error_cnt);
        $display("tag depth peaked at %0d, paren balance spanned %0d..%0d",
                 depth_peak, bal_lo, bal_hi);
        if (error_cnt == 0) begin
            $display("markup_tag_stripper_tb: clean");
        end else begin
            $display("markup_tag_stripper_tb: errors");
        end
        $finish;
    end

endmodule

### markup_tag_stripper.f
design/mts_pkg.sv
design/mts_judge.sv
design/markup_tag_stripper.sv
sim/markup_tag_stripper_tb.sv
